// ----- design/calendar_date_offset_macros.svh -----
// ----------------------------------------------------------------------------
// calendar_date_offset_macros.svh
// Assertion macros for the calendar date offset block. Both forms expect
// clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_DATE_OFFSET_MACROS_SVH
`define CALENDAR_DATE_OFFSET_MACROS_SVH

`ifndef SYNTHESIS

// property holds at every edge out of reset
`define CDO_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// pre at one edge implies post at the next edge
`define CDO_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`else

`define CDO_ASSERT(lbl, prop, msg)
`define CDO_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

// ----- design/cdo_pkg.sv -----
// ----------------------------------------------------------------------------
// cdo_pkg
// Types, codes and calendar helpers shared by the date offset block.
// ----------------------------------------------------------------------------
package cdo_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int CNT_W   = 16;
    localparam int FUNC_W  = 2;
    localparam int STAT_W  = 2;
    localparam int CENT_W  = 7;   // century and year-in-century counters
    localparam int ACC_W   = 18;  // signed day accumulator

    localparam logic [FUNC_W-1:0] FUNC_ADD  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SUB  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BAD_LOAD = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE    = 2'd2;

    localparam logic [YEAR_W-1:0]  YEAR_MIN   = 14'd1;
    localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_FIRST = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_LAST  = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_FIRST   = 5'd1;
    localparam logic [CENT_W-1:0]  CENT_LAST   = 7'd99;
    localparam logic [CENT_W-1:0]  CENT_ONE    = 7'd1;
    localparam logic [8:0]         YEAR_DAYS      = 9'd365;
    localparam logic [8:0]         LEAP_YEAR_DAYS = 9'd366;
    localparam logic [6:0]         CENTURY        = 7'd100;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DOY,
        S_OFS,
        S_YADD,
        S_YSUB,
        S_MWALK,
        S_LDIV,
        S_LCHK,
        S_FIN
    } cdo_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_START,
        OP_DOY,
        OP_OFS,
        OP_YADD,
        OP_YSUB,
        OP_MWALK,
        OP_LDIV,
        OP_LCHK,
        OP_EMIT
    } cdo_op_t;

    typedef struct packed {
        cdo_op_t op;
    } cdo_ctl_t;

    typedef struct packed {
        logic last;  // loop of the current step is finished
        logic fail;  // move left the year range
        logic sub;   // word in progress is a subtract
    } cdo_flag_t;

    // year = 100*cent + rem; cent and rem each fit 0..99
    function automatic logic is_leap(input logic [CENT_W-1:0] cent,
                                     input logic [CENT_W-1:0] rem);
        is_leap = (rem[1:0] == 2'd0) && ((rem != '0) || (cent[1:0] == 2'd0));
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    month_len = 5'd30;
            4'd2:    month_len = leap ? 5'd29 : 5'd28;
            default: month_len = 5'd0;
        endcase
    endfunction

endpackage

// ----- design/cdo_ctrl.sv -----
// ----------------------------------------------------------------------------
// cdo_ctrl
// Sequencer: steps the shared datapath through one word and owns the
// handshake state of both channels.
// ----------------------------------------------------------------------------
module cdo_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_valid,
    output logic                         cmd_stall,
    input  logic [cdo_pkg::FUNC_W-1:0]   func,
    output logic                         res_valid,
    input  logic                         res_stall,
    input  cdo_pkg::cdo_flag_t           flag,
    output cdo_pkg::cdo_ctl_t            ctl
);

    cdo_pkg::cdo_state_t state_reg, state_next;
    logic                res_valid_reg, res_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cdo_pkg::S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl.op     = cdo_pkg::OP_NONE;
        case (state_reg)
            cdo_pkg::S_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl.op = cdo_pkg::OP_START;
                    case (func)
                        cdo_pkg::FUNC_LOAD: state_next = cdo_pkg::S_LDIV;
                        cdo_pkg::FUNC_ADD,
                        cdo_pkg::FUNC_SUB:  state_next = cdo_pkg::S_DOY;
                        default:            state_next = cdo_pkg::S_FIN;
                    endcase
                end
            end
            cdo_pkg::S_DOY:
            begin
                ctl.op = cdo_pkg::OP_DOY;
                if (flag.last)
                    state_next = cdo_pkg::S_OFS;
            end
            cdo_pkg::S_OFS:
            begin
                ctl.op     = cdo_pkg::OP_OFS;
                state_next = flag.sub ? cdo_pkg::S_YSUB : cdo_pkg::S_YADD;
            end
            cdo_pkg::S_YADD:
            begin
                ctl.op = cdo_pkg::OP_YADD;
                if (flag.fail)
                    state_next = cdo_pkg::S_FIN;
                else if (flag.last)
                    state_next = cdo_pkg::S_MWALK;
            end
            cdo_pkg::S_YSUB:
            begin
                ctl.op = cdo_pkg::OP_YSUB;
                if (flag.fail)
                    state_next = cdo_pkg::S_FIN;
                else if (flag.last)
                    state_next = cdo_pkg::S_MWALK;
            end
            cdo_pkg::S_MWALK:
            begin
                ctl.op = cdo_pkg::OP_MWALK;
                if (flag.last)
                    state_next = cdo_pkg::S_FIN;
            end
            cdo_pkg::S_LDIV:
            begin
                ctl.op = cdo_pkg::OP_LDIV;
                if (flag.last)
                    state_next = cdo_pkg::S_LCHK;
            end
            cdo_pkg::S_LCHK:
            begin
                ctl.op     = cdo_pkg::OP_LCHK;
                state_next = cdo_pkg::S_FIN;
            end
            cdo_pkg::S_FIN:
            begin
                // wait for the output register to free up
                if (!res_valid_reg || !res_stall)
                begin
                    ctl.op     = cdo_pkg::OP_EMIT;
                    state_next = cdo_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = cdo_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (ctl.op == cdo_pkg::OP_EMIT)
            res_valid_next = 1'b1;
        else if (res_valid_reg && !res_stall)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    assign cmd_stall = (state_reg != cdo_pkg::S_IDLE);
    assign res_valid = res_valid_reg;

endmodule

// ----- design/cdo_dp.sv -----
// ----------------------------------------------------------------------------
// cdo_dp
// Datapath: stored date, working registers and the one shared day adder
// that walks months and years and divides a loaded year by 100.
// ----------------------------------------------------------------------------
module cdo_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cdo_pkg::cdo_ctl_t             ctl,
    output cdo_pkg::cdo_flag_t            flag,
    input  logic [cdo_pkg::FUNC_W-1:0]    func,
    input  logic [cdo_pkg::CNT_W-1:0]     day_count,
    input  logic [cdo_pkg::YEAR_W-1:0]    new_year,
    input  logic [cdo_pkg::MONTH_W-1:0]   new_month,
    input  logic [cdo_pkg::DAY_W-1:0]     new_day,
    output logic [cdo_pkg::YEAR_W-1:0]    cur_year,
    output logic [cdo_pkg::MONTH_W-1:0]   cur_month,
    output logic [cdo_pkg::DAY_W-1:0]     cur_day,
    output logic [cdo_pkg::STAT_W-1:0]    status
);

    localparam int AW = cdo_pkg::ACC_W;
    localparam int CW = cdo_pkg::CENT_W;
    localparam logic [cdo_pkg::DAY_W-1:0] DAY_ONE = cdo_pkg::DAY_FIRST;

    // stored date, with the year also kept as century / year-in-century
    logic [cdo_pkg::YEAR_W-1:0]  year_reg, year_next;
    logic [CW-1:0]               cent_reg, cent_next;
    logic [CW-1:0]               yrem_reg, yrem_next;
    logic [cdo_pkg::MONTH_W-1:0] month_reg, month_next;
    logic [cdo_pkg::DAY_W-1:0]   day_reg, day_next;

    // captured word
    logic [cdo_pkg::FUNC_W-1:0]  func_reg, func_next;
    logic [cdo_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [cdo_pkg::YEAR_W-1:0]  ny_reg, ny_next;
    logic [cdo_pkg::MONTH_W-1:0] nm_reg, nm_next;
    logic [cdo_pkg::DAY_W-1:0]   nd_reg, nd_next;

    // working date
    logic [cdo_pkg::YEAR_W-1:0]  wy_reg, wy_next;
    logic [CW-1:0]               wq_reg, wq_next;
    logic [CW-1:0]               wr_reg, wr_next;
    logic [cdo_pkg::MONTH_W-1:0] wm_reg, wm_next;
    logic signed [AW-1:0]        wn_reg, wn_next;
    logic [cdo_pkg::STAT_W-1:0]  stat_reg, stat_next;

    // result register
    logic [cdo_pkg::YEAR_W-1:0]  oy_reg, oy_next;
    logic [cdo_pkg::MONTH_W-1:0] om_reg, om_next;
    logic [cdo_pkg::DAY_W-1:0]   od_reg, od_next;
    logic [cdo_pkg::STAT_W-1:0]  os_reg, os_next;

    // shared adder
    logic [AW-1:0]               add_b;
    logic                        add_sub;
    logic signed [AW-1:0]        add_sum;
    logic                        sum_neg;

    logic                        leap_w, leap_p, leap_ld, load_ok;
    logic [CW-1:0]               pq, pr;
    logic [cdo_pkg::DAY_W-1:0]   mlen_w, mlen_ld;
    logic [8:0]                  ylen_w, ylen_p;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_reg  <= cdo_pkg::YEAR_MIN;
            cent_reg  <= '0;
            yrem_reg  <= cdo_pkg::CENT_ONE;
            month_reg <= cdo_pkg::MONTH_FIRST;
            day_reg   <= cdo_pkg::DAY_FIRST;
        end
        else
        begin
            year_reg  <= year_next;
            cent_reg  <= cent_next;
            yrem_reg  <= yrem_next;
            month_reg <= month_next;
            day_reg   <= day_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        cnt_reg  <= cnt_next;
        ny_reg   <= ny_next;
        nm_reg   <= nm_next;
        nd_reg   <= nd_next;
        wy_reg   <= wy_next;
        wq_reg   <= wq_next;
        wr_reg   <= wr_next;
        wm_reg   <= wm_next;
        wn_reg   <= wn_next;
        stat_reg <= stat_next;
        oy_reg   <= oy_next;
        om_reg   <= om_next;
        od_reg   <= od_next;
        os_reg   <= os_next;
    end

    // calendar lookups on the working year, on the year before it and on the date to load
    always_comb
    begin
        pq      = (wr_reg == '0) ? wq_reg - cdo_pkg::CENT_ONE : wq_reg;
        pr      = (wr_reg == '0) ? cdo_pkg::CENT_LAST : wr_reg - cdo_pkg::CENT_ONE;
        leap_w  = cdo_pkg::is_leap(wq_reg, wr_reg);
        leap_p  = cdo_pkg::is_leap(pq, pr);
        ylen_w  = leap_w ? cdo_pkg::LEAP_YEAR_DAYS : cdo_pkg::YEAR_DAYS;
        ylen_p  = leap_p ? cdo_pkg::LEAP_YEAR_DAYS : cdo_pkg::YEAR_DAYS;
        mlen_w  = cdo_pkg::month_len(wm_reg, leap_w);
        leap_ld = cdo_pkg::is_leap(wq_reg, wn_reg[CW-1:0]);
        mlen_ld = cdo_pkg::month_len(nm_reg, leap_ld);
        load_ok = (ny_reg >= cdo_pkg::YEAR_MIN) && (ny_reg <= cdo_pkg::YEAR_MAX) &&
                  (nd_reg != '0) && (nd_reg <= mlen_ld);
    end

    // operand select for the shared adder
    always_comb
    begin
        add_b   = '0;
        add_sub = 1'b0;
        case (ctl.op)
            cdo_pkg::OP_DOY:   add_b = AW'(mlen_w);
            cdo_pkg::OP_OFS:
            begin
                add_b   = AW'(cnt_reg);
                add_sub = (func_reg == cdo_pkg::FUNC_SUB);
            end
            cdo_pkg::OP_YADD:
            begin
                add_b   = AW'(ylen_w);
                add_sub = 1'b1;
            end
            cdo_pkg::OP_YSUB:  add_b = AW'(ylen_p);
            cdo_pkg::OP_MWALK:
            begin
                add_b   = AW'(mlen_w);
                add_sub = 1'b1;
            end
            cdo_pkg::OP_LDIV:
            begin
                add_b   = AW'(cdo_pkg::CENTURY);
                add_sub = 1'b1;
            end
            default:
            begin
                add_b   = '0;
                add_sub = 1'b0;
            end
        endcase
        add_sum = wn_reg + $signed(add_b ^ {AW{add_sub}}) + $signed(AW'(add_sub));
        sum_neg = add_sum[AW-1];
    end

    // loop exit and failure flags for the sequencer
    always_comb
    begin
        flag.last = 1'b1;
        flag.fail = 1'b0;
        flag.sub  = (func_reg == cdo_pkg::FUNC_SUB);
        case (ctl.op)
            cdo_pkg::OP_DOY:   flag.last = !(wm_reg < month_reg);
            cdo_pkg::OP_YADD:
            begin
                flag.last = sum_neg;
                flag.fail = !sum_neg && (wy_reg == cdo_pkg::YEAR_MAX);
            end
            cdo_pkg::OP_YSUB:
            begin
                flag.last = !wn_reg[AW-1];
                flag.fail = wn_reg[AW-1] && (wy_reg == cdo_pkg::YEAR_MIN);
            end
            cdo_pkg::OP_MWALK: flag.last = (wm_reg == cdo_pkg::MONTH_LAST) || sum_neg;
            cdo_pkg::OP_LDIV:  flag.last = sum_neg;
            default:           flag.last = 1'b1;
        endcase
    end

    always_comb
    begin
        year_next  = year_reg;
        cent_next  = cent_reg;
        yrem_next  = yrem_reg;
        month_next = month_reg;
        day_next   = day_reg;
        func_next  = func_reg;
        cnt_next   = cnt_reg;
        ny_next    = ny_reg;
        nm_next    = nm_reg;
        nd_next    = nd_reg;
        wy_next    = wy_reg;
        wq_next    = wq_reg;
        wr_next    = wr_reg;
        wm_next    = wm_reg;
        wn_next    = wn_reg;
        stat_next  = stat_reg;
        oy_next    = oy_reg;
        om_next    = om_reg;
        od_next    = od_reg;
        os_next    = os_reg;
        case (ctl.op)
            cdo_pkg::OP_START:
            begin
                func_next = func;
                cnt_next  = day_count;
                ny_next   = new_year;
                nm_next   = new_month;
                nd_next   = new_day;
                stat_next = cdo_pkg::STAT_OK;
                wy_next   = year_reg;
                wq_next   = (func == cdo_pkg::FUNC_LOAD) ? '0 : cent_reg;
                wr_next   = yrem_reg;
                wm_next   = cdo_pkg::MONTH_FIRST;
                // load divides the new year by 100 in wn; moves start at the zero-based day of month
                wn_next   = (func == cdo_pkg::FUNC_LOAD) ? $signed(AW'(new_year))
                                                         : $signed(AW'(day_reg - DAY_ONE));
            end
            cdo_pkg::OP_DOY:
            begin
                if (!flag.last)
                begin
                    wn_next = add_sum;
                    wm_next = wm_reg + cdo_pkg::MONTH_FIRST;
                end
            end
            cdo_pkg::OP_OFS:
            begin
                wn_next = add_sum;
            end
            cdo_pkg::OP_YADD:
            begin
                if (flag.fail)
                    stat_next = cdo_pkg::STAT_RANGE;
                else if (flag.last)
                    wm_next = cdo_pkg::MONTH_FIRST;
                else
                begin
                    wn_next = add_sum;
                    wy_next = wy_reg + cdo_pkg::YEAR_MIN;
                    if (wr_reg == cdo_pkg::CENT_LAST)
                    begin
                        wr_next = '0;
                        wq_next = wq_reg + cdo_pkg::CENT_ONE;
                    end
                    else
                        wr_next = wr_reg + cdo_pkg::CENT_ONE;
                end
            end
            cdo_pkg::OP_YSUB:
            begin
                if (flag.fail)
                    stat_next = cdo_pkg::STAT_RANGE;
                else if (flag.last)
                    wm_next = cdo_pkg::MONTH_FIRST;
                else
                begin
                    wn_next = add_sum;
                    wy_next = wy_reg - cdo_pkg::YEAR_MIN;
                    wq_next = pq;
                    wr_next = pr;
                end
            end
            cdo_pkg::OP_MWALK:
            begin
                if (flag.last)
                begin
                    year_next  = wy_reg;
                    cent_next  = wq_reg;
                    yrem_next  = wr_reg;
                    month_next = wm_reg;
                    day_next   = wn_reg[cdo_pkg::DAY_W-1:0] + DAY_ONE;
                end
                else
                begin
                    wn_next = add_sum;
                    wm_next = wm_reg + cdo_pkg::MONTH_FIRST;
                end
            end
            cdo_pkg::OP_LDIV:
            begin
                if (!flag.last)
                begin
                    wn_next = add_sum;
                    wq_next = wq_reg + cdo_pkg::CENT_ONE;
                end
            end
            cdo_pkg::OP_LCHK:
            begin
                if (load_ok)
                begin
                    year_next  = ny_reg;
                    cent_next  = wq_reg;
                    yrem_next  = wn_reg[CW-1:0];
                    month_next = nm_reg;
                    day_next   = nd_reg;
                end
                else
                    stat_next = cdo_pkg::STAT_BAD_LOAD;
            end
            cdo_pkg::OP_EMIT:
            begin
                oy_next = year_reg;
                om_next = month_reg;
                od_next = day_reg;
                os_next = stat_reg;
            end
            default:
            begin
                stat_next = stat_reg;
            end
        endcase
    end

    assign cur_year  = oy_reg;
    assign cur_month = om_reg;
    assign cur_day   = od_reg;
    assign status    = os_reg;

endmodule

// ----- design/calendar_date_offset.sv -----
// ----------------------------------------------------------------------------
// calendar_date_offset
// Keeps one Gregorian date; loads it, or moves it by a day count.
// A move runs the month sum, a walk of one year per step and the month walk,
// all on the shared day adder; a load runs the divide-by-100 loop, for years
// 1..9999 and for out-of-range years alike.
// One word at a time: cmd_stall stays high until the result is registered.
// Reset: date 0001-01-01, no result pending.
// ----------------------------------------------------------------------------
`include "calendar_date_offset_macros.svh"

module calendar_date_offset (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_stall,
    input  logic [cdo_pkg::FUNC_W-1:0]    func,
    input  logic [cdo_pkg::CNT_W-1:0]     day_count,
    input  logic [cdo_pkg::YEAR_W-1:0]    new_year,
    input  logic [cdo_pkg::MONTH_W-1:0]   new_month,
    input  logic [cdo_pkg::DAY_W-1:0]     new_day,
    output logic                          res_valid,
    input  logic                          res_stall,
    output logic [cdo_pkg::YEAR_W-1:0]    cur_year,
    output logic [cdo_pkg::MONTH_W-1:0]   cur_month,
    output logic [cdo_pkg::DAY_W-1:0]     cur_day,
    output logic [cdo_pkg::STAT_W-1:0]    status
);

    cdo_pkg::cdo_ctl_t  ctl;
    cdo_pkg::cdo_flag_t flag;

    cdo_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .func      (func),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .flag      (flag),
        .ctl       (ctl)
    );

    cdo_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .flag      (flag),
        .func      (func),
        .day_count (day_count),
        .new_year  (new_year),
        .new_month (new_month),
        .new_day   (new_day),
        .cur_year  (cur_year),
        .cur_month (cur_month),
        .cur_day   (cur_day),
        .status    (status)
    );

    // busy right after taking a word
    `CDO_ASSERT_NEXT(a_busy_after_accept, cmd_valid && !cmd_stall, cmd_stall, "not busy after accept")

    // a result always carries a legal date
    `CDO_ASSERT(a_res_date_legal, !res_valid || (cur_month >= cdo_pkg::MONTH_FIRST && cur_month <= cdo_pkg::MONTH_LAST && cur_day != '0 && cur_year >= cdo_pkg::YEAR_MIN && cur_year <= cdo_pkg::YEAR_MAX), "illegal date on result")

    // the sequencer only emits from the result stage, never while accepting
    `CDO_ASSERT(a_emit_not_idle, !(ctl.op == cdo_pkg::OP_EMIT && !cmd_stall), "emit while idle")

endmodule
